[sv/urlpc_pkg.sv]
// package: shared types, character constants and helper functions of the url codec
`timescale 1ns / 1ps
`default_nettype none

package urlpc_pkg;

    localparam int unsigned MAX_RESULTS = 3;

    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_TILDE   = 8'h7E;
    localparam logic [7:0] CHAR_DASH    = 8'h2D;
    localparam logic [7:0] CHAR_UNDER   = 8'h5F;
    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_UP_A    = 8'h41;
    localparam logic [7:0] CHAR_UP_F    = 8'h46;
    localparam logic [7:0] CHAR_UP_Z    = 8'h5A;
    localparam logic [7:0] CHAR_LO_A    = 8'h61;
    localparam logic [7:0] CHAR_LO_F    = 8'h66;
    localparam logic [7:0] CHAR_LO_Z    = 8'h7A;

    localparam logic [7:0] HEX_ALPHA_OFS = 8'd55;
    localparam logic [7:0] HEX_DIGIT_OFS = 8'd48;
    localparam logic [4:0] NO_DIGIT      = 5'd16;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_UPPER = 2'd1,
        PH_LOWER = 2'd2
    } esc_phase_t;

    typedef struct packed {
        esc_phase_t  phase;
        logic [3:0]  upper;
        logic        invalid;
    } esc_state_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        run_last;
        logic        string_end;
        logic        bad_escape;
    } result_t;

    typedef struct packed {
        logic [1:0]  count;
        result_t     r2;
        result_t     r1;
        result_t     r0;
    } result_set_t;

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] w;
        w = {4'h0, v};
        return (v > 4'd9) ? w + HEX_ALPHA_OFS : w + HEX_DIGIT_OFS;
    endfunction

    // digit value, or NO_DIGIT when c is not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d = c - CHAR_ZERO;
        end
        else if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
            d = c - CHAR_UP_A + 8'd10;
        end
        else if (c >= CHAR_LO_A && c <= CHAR_LO_F) begin
            d = c - CHAR_LO_A + 8'd10;
        end
        else begin
            d = {3'b000, NO_DIGIT};
        end
        return d[4:0];
    endfunction

    function automatic logic passes_through(input logic [7:0] c);
        return (c >= CHAR_ZERO && c <= CHAR_NINE) || (c >= CHAR_UP_A && c <= CHAR_UP_Z) ||
               (c >= CHAR_LO_A && c <= CHAR_LO_Z) || c == CHAR_DASH || c == CHAR_UNDER ||
               c == CHAR_DOT || c == CHAR_TILDE;
    endfunction

endpackage

`default_nettype wire

[sv/urlpc_ifs.sv]
// interfaces: byte request channel, result channel and direction write channel
`timescale 1ns / 1ps
`default_nettype none

interface urlpc_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  in_byte;
    logic        in_final;

    modport source (output valid, output in_byte, output in_final, input ready);
    modport sink   (input valid, input in_byte, input in_final, output ready);
endinterface

interface urlpc_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        run_last;
    logic        string_end;
    logic        bad_escape;

    modport source (output valid, output out_byte, output run_last, output string_end,
                    output bad_escape, input ready);
    modport sink   (input valid, input out_byte, input run_last, input string_end,
                    input bad_escape, output ready);
endinterface

interface urlpc_cfg_if;
    logic        valid;
    logic        ready;
    logic        direction;

    modport source (output valid, output direction, input ready);
    modport sink   (input valid, input direction, output ready);
endinterface

`default_nettype wire

[sv/urlpc_xlate.sv]
// translation logic: one input byte plus escape state to up to three results
`timescale 1ns / 1ps
`default_nettype none

module urlpc_xlate
    import urlpc_pkg::*;
(
    input  wire logic        direction,
    input  wire logic [7:0]  in_byte,
    input  wire logic        in_final,
    input  wire esc_state_t  esc,
    output result_set_t      results,
    output esc_state_t       esc_next
);

    localparam esc_state_t ESC_CLEAR = '{phase: PH_IDLE, upper: 4'h0, invalid: 1'b0};

    logic [4:0] digit;

    assign digit = hex_value(in_byte);

    always_comb
    begin
        results  = '0;
        esc_next = esc;
        if (direction == DIR_ENCODE) begin
            if (passes_through(in_byte)) begin
                results.count = 2'd1;
                results.r0    = '{out_byte: in_byte, run_last: 1'b1,
                                  string_end: in_final, bad_escape: 1'b0};
            end
            else if (in_byte == CHAR_SPACE) begin
                results.count = 2'd1;
                results.r0    = '{out_byte: CHAR_PLUS, run_last: 1'b1,
                                  string_end: in_final, bad_escape: 1'b0};
            end
            else begin
                results.count = 2'd3;
                results.r0    = '{out_byte: CHAR_PERCENT, run_last: 1'b0,
                                  string_end: 1'b0, bad_escape: 1'b0};
                results.r1    = '{out_byte: hex_char(in_byte[7:4]), run_last: 1'b0,
                                  string_end: 1'b0, bad_escape: 1'b0};
                results.r2    = '{out_byte: hex_char(in_byte[3:0]), run_last: 1'b1,
                                  string_end: in_final, bad_escape: 1'b0};
            end
        end
        else begin
            unique case (esc.phase)
                PH_UPPER:
                begin
                    esc_next.phase   = PH_LOWER;
                    esc_next.upper   = digit[3:0];
                    esc_next.invalid = digit[4];
                    if (in_final) begin
                        // string ends on the upper digit
                        esc_next      = ESC_CLEAR;
                        results.count = 2'd1;
                        results.r0    = '{out_byte: 8'h00, run_last: 1'b1,
                                          string_end: 1'b1, bad_escape: 1'b1};
                    end
                end
                PH_LOWER:
                begin
                    esc_next      = ESC_CLEAR;
                    results.count = 2'd1;
                    if (esc.invalid || digit[4]) begin
                        results.r0 = '{out_byte: 8'h00, run_last: 1'b1,
                                       string_end: in_final, bad_escape: 1'b1};
                    end
                    else begin
                        results.r0 = '{out_byte: {esc.upper, digit[3:0]}, run_last: 1'b1,
                                       string_end: in_final, bad_escape: 1'b0};
                    end
                end
                default:
                begin
                    esc_next.phase = PH_IDLE;
                    if (in_byte == CHAR_PERCENT) begin
                        if (in_final) begin
                            esc_next      = ESC_CLEAR;
                            results.count = 2'd1;
                            results.r0    = '{out_byte: 8'h00, run_last: 1'b1,
                                              string_end: 1'b1, bad_escape: 1'b1};
                        end
                        else begin
                            esc_next.phase = PH_UPPER;
                        end
                    end
                    else if (in_byte == CHAR_PLUS) begin
                        results.count = 2'd1;
                        results.r0    = '{out_byte: CHAR_SPACE, run_last: 1'b1,
                                          string_end: in_final, bad_escape: 1'b0};
                    end
                    else begin
                        results.count = 2'd1;
                        results.r0    = '{out_byte: in_byte, run_last: 1'b1,
                                          string_end: in_final, bad_escape: 1'b0};
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[sv/url_percent_codec.sv]
// top level: url percent codec with request channel, result buffer and direction register
// Usage:
//   rx   byte requests (in_byte, in_final), taken when valid and ready are high
//   tx   result bytes (out_byte, run_last, string_end, bad_escape)
//   cfg  direction write: 0 encodes, 1 decodes; always ready, also clears escape state
// A request is translated in the cycle it is taken and its zero to three results
// land in a three-entry result register; tx shows the first one in the next cycle.
// Throughput: a request every cycle while each gives at most one result and tx is
// ready; an encode request that escapes a byte holds rx until the single-byte tx
// channel has drained the result register down to its last entry.
// rx is ready while the result register is empty or sends its last entry that cycle.
// When tx stalls, the current result holds and rx stops while the register holds any result.
// Reset sets direction to encode, clears the escape state and empties the result register.
// The user must write direction only while no request is in flight; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module url_percent_codec
    import urlpc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    urlpc_cfg_if.sink   cfg,
    urlpc_in_if.sink    rx,
    urlpc_out_if.source tx
);

    logic        dir_reg;
    esc_state_t  esc_reg;
    esc_state_t  esc_next;
    result_set_t res_now;
    logic [1:0]  rem_reg;
    logic [1:0]  rem_next;
    result_t     buf_reg [MAX_RESULTS];
    logic        acc;
    logic        pop;
    logic        cfg_wr;

    urlpc_xlate u_xlate (
        .direction (dir_reg),
        .in_byte   (rx.in_byte),
        .in_final  (rx.in_final),
        .esc       (esc_reg),
        .results   (res_now),
        .esc_next  (esc_next)
    );

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;

    assign pop      = tx.valid && tx.ready;
    assign rx.ready = (rem_reg == 2'd0) || (rem_reg == 2'd1 && tx.ready);
    assign acc      = rx.valid && rx.ready;

    assign tx.valid      = (rem_reg != 2'd0);
    assign tx.out_byte   = buf_reg[0].out_byte;
    assign tx.run_last   = buf_reg[0].run_last;
    assign tx.string_end = buf_reg[0].string_end;
    assign tx.bad_escape = buf_reg[0].bad_escape;

    always_comb
    begin
        priority if (acc) begin
            rem_next = res_now.count;
        end
        else if (pop) begin
            rem_next = rem_reg - 2'd1;
        end
        else begin
            rem_next = rem_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            dir_reg <= DIR_ENCODE;
            esc_reg <= '{phase: PH_IDLE, upper: 4'h0, invalid: 1'b0};
            rem_reg <= 2'd0;
        end
        else begin
            rem_reg <= rem_next;
            if (cfg_wr) begin
                dir_reg <= cfg.direction;
                esc_reg <= '{phase: PH_IDLE, upper: 4'h0, invalid: 1'b0};
            end
            else if (acc) begin
                esc_reg <= esc_next;
            end
        end
    end

    // result register: load on request, shift down on each sent result
    always_ff @(posedge clk)
    begin
        if (acc) begin
            buf_reg[0] <= res_now.r0;
            buf_reg[1] <= res_now.r1;
            buf_reg[2] <= res_now.r2;
        end
        else if (pop) begin
            buf_reg[0] <= buf_reg[1];
            buf_reg[1] <= buf_reg[2];
        end
    end

    a_encode_keeps_escape: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && dir_reg == DIR_ENCODE && !cfg_wr) |=> esc_reg == $past(esc_reg))
        else $error("escape state changed in encode mode");

    a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (tx.valid && tx.bad_escape) |-> tx.out_byte == 8'h00)
        else $error("error result carries a nonzero byte");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (tx.valid && tx.string_end) |-> tx.run_last)
        else $error("string end on a result that is not the last of its request");

    a_bad_only_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (tx.valid && tx.bad_escape) |-> dir_reg == DIR_DECODE)
        else $error("error result while encoding");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (tx.valid && !tx.ready) |=> rem_reg == $past(rem_reg))
        else $error("result count moved while tx stalled");

endmodule

`default_nettype wire

[sim/url_percent_codec_tb.sv]
// testbench: url percent codec checked result by result against a byte-level predictor
`timescale 1ns / 1ps

module url_percent_codec_tb;
    import urlpc_pkg::*;

    localparam int IDLE_PCT       = 7;
    localparam int HOLDOFF_CYCLES = 80;
    localparam int PHASE_ITEMS    = 75;
    localparam int SETTLE_CYCLES  = 4;

    logic clk;
    logic rst_n;

    urlpc_cfg_if cfg_ch ();
    urlpc_in_if  req_ch ();
    urlpc_out_if res_ch ();

    url_percent_codec dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .rx    (req_ch),
        .tx    (res_ch)
    );

    // predictor copy of the direction register and escape state
    logic       mdl_dir;
    esc_phase_t mdl_phase;
    logic [3:0] mdl_upper;
    logic       mdl_invalid;

    result_t    pending_results[$];
    logic [7:0] text[$];
    int         mismatches;
    int         requests_sent;
    int         strings_sent;
    int         results_seen;
    logic       no_idle;
    logic       hold_tx;
    event       holdoff_ev;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic is_plain(input logic [7:0] c);
        logic [7:0] folded;
        // setting bit 5 maps upper case letters onto lower case
        folded = c | 8'h20;
        return (folded >= CHAR_LO_A && folded <= CHAR_LO_Z) ||
               (c >= CHAR_ZERO && c <= CHAR_NINE) ||
               c == CHAR_DASH || c == CHAR_UNDER || c == CHAR_DOT || c == CHAR_TILDE;
    endfunction

    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        logic [7:0] folded;
        folded = c | 8'h20;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            return {1'b0, c[3:0]};
        end
        if (folded >= CHAR_LO_A && folded <= CHAR_LO_F)
        begin
            return {1'b0, c[3:0] + 4'd9};
        end
        return NO_DIGIT;
    endfunction

    function automatic logic [7:0] hex_ascii(input logic [3:0] n);
        return (n > 4'd9) ? {4'h0, n} - 8'd10 + CHAR_UP_A : {4'h0, n} + CHAR_ZERO;
    endfunction

    function automatic void close_escape();
        mdl_phase   = PH_IDLE;
        mdl_upper   = 4'h0;
        mdl_invalid = 1'b0;
    endfunction

    function automatic void expect_result(input logic [7:0] b, input logic last,
                                          input logic end_flag, input logic bad);
        result_t r;
        r.out_byte   = b;
        r.run_last   = last;
        r.string_end = end_flag;
        r.bad_escape = bad;
        pending_results.push_back(r);
    endfunction

    function automatic void predict_request(input logic [7:0] b, input logic fin);
        logic [4:0] digit;
        digit = nibble_of(b);
        if (mdl_dir == DIR_ENCODE)
        begin
            if (is_plain(b))
            begin
                expect_result(b, 1'b1, fin, 1'b0);
            end
            else if (b == CHAR_SPACE)
            begin
                expect_result(CHAR_PLUS, 1'b1, fin, 1'b0);
            end
            else
            begin
                expect_result(CHAR_PERCENT, 1'b0, 1'b0, 1'b0);
                expect_result(hex_ascii(b[7:4]), 1'b0, 1'b0, 1'b0);
                expect_result(hex_ascii(b[3:0]), 1'b1, fin, 1'b0);
            end
            return;
        end
        case (mdl_phase)
            PH_UPPER:
            begin
                if (fin)
                begin
                    // string ends on the upper digit
                    expect_result(8'h00, 1'b1, 1'b1, 1'b1);
                end
                else
                begin
                    mdl_upper   = digit[3:0];
                    mdl_invalid = digit[4];
                    mdl_phase   = PH_LOWER;
                end
            end
            PH_LOWER:
            begin
                if (mdl_invalid || digit[4])
                begin
                    expect_result(8'h00, 1'b1, fin, 1'b1);
                end
                else
                begin
                    expect_result({mdl_upper, digit[3:0]}, 1'b1, fin, 1'b0);
                end
                close_escape();
            end
            default:
            begin
                mdl_phase = PH_IDLE;
                if (b == CHAR_PERCENT)
                begin
                    if (fin)
                    begin
                        expect_result(8'h00, 1'b1, 1'b1, 1'b1);
                    end
                    else
                    begin
                        mdl_phase = PH_UPPER;
                    end
                end
                else if (b == CHAR_PLUS)
                begin
                    expect_result(CHAR_SPACE, 1'b1, fin, 1'b0);
                end
                else
                begin
                    expect_result(b, 1'b1, fin, 1'b0);
                end
            end
        endcase
        if (fin)
        begin
            close_escape();
        end
    endfunction

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_result();
        result_t want;
        results_seen++;
        if (pending_results.size() == 0)
        begin
            $error("unexpected result: out_byte %0h", res_ch.out_byte);
            mismatches++;
            return;
        end
        want = pending_results.pop_front();
        compare_field("out_byte", want.out_byte, res_ch.out_byte);
        compare_field("run_last", {7'd0, want.run_last}, {7'd0, res_ch.run_last});
        compare_field("string_end", {7'd0, want.string_end}, {7'd0, res_ch.string_end});
        compare_field("bad_escape", {7'd0, want.bad_escape}, {7'd0, res_ch.bad_escape});
    endfunction

    // result side: check, then choose ready for the next cycle
    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
            begin
                check_result();
            end
            res_ch.ready <= rst_n && !hold_tx &&
                            (no_idle || $urandom_range(99) >= IDLE_PCT);
        end
    end

    // long receiver hold-off so the result register fills and rx stalls
    initial
    begin
        hold_tx = 1'b0;
        forever
        begin
            @(holdoff_ev);
            @(posedge clk);
            hold_tx <= 1'b1;
            repeat (HOLDOFF_CYCLES) @(posedge clk);
            hold_tx <= 1'b0;
        end
    end

    task automatic send_request(input logic [7:0] b, input logic fin);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.in_byte  <= b;
        req_ch.in_final <= fin;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        predict_request(b, fin);
        requests_sent++;
    endtask

    task automatic send_text();
        foreach (text[i])
        begin
            send_request(text[i], i == text.size() - 1);
        end
        strings_sent++;
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        // a '%' or upper digit gives no result and may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_direction(input logic d);
        wait_idle();
        cfg_ch.valid     <= 1'b1;
        cfg_ch.direction <= d;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        mdl_dir = d;
        close_escape();
    endtask

    function automatic logic [7:0] random_hex_char();
        logic [3:0] n;
        n = 4'($urandom_range(15));
        if (n < 4'd10)
        begin
            return {4'h0, n} + CHAR_ZERO;
        end
        return {4'h0, n} - 8'd10 + ($urandom_range(1) ? CHAR_LO_A : CHAR_UP_A);
    endfunction

    function automatic logic [7:0] random_non_hex();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        while (nibble_of(c) != NO_DIGIT) c = 8'($urandom_range(255));
        return c;
    endfunction

    // well formed escapes with random digits, plus noise and broken escapes
    function automatic void build_decode_text();
        int units;
        logic [7:0] raw;
        units = $urandom_range(1, 5);
        text.delete();
        repeat (units)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3:
                begin
                    text.push_back(CHAR_PERCENT);
                    text.push_back(random_hex_char());
                    text.push_back(random_hex_char());
                end
                4: text.push_back(CHAR_PLUS);
                5:
                begin
                    text.push_back(CHAR_PERCENT);
                    if ($urandom_range(1))
                    begin
                        text.push_back(random_non_hex());
                        raw = 8'($urandom_range(255));
                        text.push_back(raw);
                    end
                    else
                    begin
                        text.push_back(random_hex_char());
                        text.push_back(random_non_hex());
                    end
                end
                6, 7, 8:
                begin
                    raw = 8'($urandom_range(255));
                    text.push_back(raw);
                end
                default: text.push_back(CHAR_PERCENT);
            endcase
        end
        // sometimes the string stops inside an escape
        if ($urandom_range(7) == 0)
        begin
            text.push_back(CHAR_PERCENT);
            if ($urandom_range(1))
            begin
                text.push_back(random_hex_char());
            end
        end
    endfunction

    function automatic void build_encode_text();
        int len;
        logic [7:0] raw;
        len = $urandom_range(1, 6);
        text.delete();
        repeat (len)
        begin
            raw = 8'($urandom_range(255));
            text.push_back($urandom_range(4) == 0 ? CHAR_SPACE : raw);
        end
    endfunction

    task automatic test_encode_directed();
        write_direction(DIR_ENCODE);
        send_request(CHAR_LO_A, 1'b0);
        send_request(CHAR_UP_Z, 1'b0);
        send_request(CHAR_NINE, 1'b0);
        send_request(CHAR_TILDE, 1'b0);
        send_request(CHAR_SPACE, 1'b0);
        send_request(8'h00, 1'b0);
        send_request(CHAR_PERCENT, 1'b0);
        send_request(8'hFF, 1'b1);
    endtask

    task automatic test_decode_directed();
        write_direction(DIR_DECODE);
        // good escape, plus, bad upper digit, bad lower digit, escape closing the string
        text = {CHAR_PERCENT, 8'h34, 8'h61, CHAR_PLUS,
                CHAR_PERCENT, 8'h67, 8'h31, CHAR_PERCENT, 8'h32, 8'h7A,
                CHAR_PERCENT, CHAR_LO_F, CHAR_UP_F};
        send_text();
        // cut short on the upper digit, then on the percent itself
        send_request(CHAR_PERCENT, 1'b0);
        send_request(CHAR_UP_F, 1'b1);
        send_request(CHAR_PERCENT, 1'b1);
        // open escape is dropped by a direction write
        send_request(CHAR_PERCENT, 1'b0);
        send_request(8'h34, 1'b0);
        write_direction(DIR_DECODE);
        send_request(8'hFF, 1'b1);
    endtask

    task automatic test_random_strings(input logic d, input int items, input logic quiet);
        int start_count;
        write_direction(d);
        no_idle <= quiet;
        start_count = requests_sent;
        while (requests_sent - start_count < items)
        begin
            if (d == DIR_DECODE)
            begin
                build_decode_text();
            end
            else
            begin
                build_encode_text();
            end
            send_text();
        end
        wait_idle();
        no_idle <= 1'b0;
    endtask

    task automatic test_backpressure();
        logic [7:0] raw;
        write_direction(DIR_ENCODE);
        -> holdoff_ev;
        text.delete();
        // high bytes always escape, so every request makes three results
        repeat (20)
        begin
            raw = 8'($urandom_range(128, 255));
            text.push_back(raw);
        end
        send_text();
        wait_idle();
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.in_byte     <= 8'h00;
        req_ch.in_final    <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.direction   <= DIR_ENCODE;
        no_idle            <= 1'b0;
        mismatches    = 0;
        requests_sent = 0;
        strings_sent  = 0;
        results_seen  = 0;
        mdl_dir       = DIR_ENCODE;
        close_escape();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_encode_directed();
        test_decode_directed();
        test_random_strings(DIR_ENCODE, PHASE_ITEMS, 1'b1);
        test_random_strings(DIR_DECODE, PHASE_ITEMS, 1'b0);
        test_backpressure();
        test_random_strings(DIR_DECODE, PHASE_ITEMS, 1'b1);
        test_random_strings(DIR_ENCODE, PHASE_ITEMS, 1'b0);

        wait_idle();
        repeat (8) @(posedge clk);
        $display("covered %0d requests in %0d strings, %0d results checked, %0d mismatches",
                 requests_sent, strings_sent, results_seen, mismatches);
        $display("both directions, escapes good, bad and cut short, idling and a long tx stall");
        if (mismatches == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $error("timeout with %0d results outstanding", pending_results.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
